@@ hw/rtl/scmn_pkg.sv @@
`timescale 1ns / 1ps
package scmn_pkg;
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int MAT_AW = ROW_AW + COL_AW;
  localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int SIZE_W = 9;
  localparam int CNT_W = 32;
  localparam int SUM_W = 40;
  localparam int PROD_W = 2 * SUM_W;
  localparam int VAL_W = 33;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ROW_ERR = 2'd1,
    ST_COL_ERR = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR    = 2'd2;

  // Handshake between the sequencer and an iterative arithmetic unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;
endpackage

@@ hw/rtl/scmn_ram.sv @@
`timescale 1ns / 1ps
module scmn_ram #(
  parameter int W = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/scmn_isqrt.sv @@
`timescale 1ns / 1ps
module scmn_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  scmn_pkg::unit_req_t        req,
  input  logic [scmn_pkg::PROD_W-1:0] radicand,
  output scmn_pkg::unit_rsp_t        rsp,
  output logic [scmn_pkg::SUM_W-1:0] root
);
  import scmn_pkg::*;

  localparam int REM_W = SUM_W + 3;
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [PROD_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              running;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // One result bit per cycle: bring down two radicand bits, try root*4+1.
  assign rem_sh = {rem[REM_W-3:0], rad[PROD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        rad <= radicand;
        rem <= '0;
        root <= '0;
        steps <= STEP_W'(SUM_W);
      end else if (running) begin
        rad <= rad << 2;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[SUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/scmn_div.sv @@
`timescale 1ns / 1ps
module scmn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  scmn_pkg::unit_req_t        req,
  input  logic [scmn_pkg::CNT_W-1:0] entry,
  input  logic [scmn_pkg::SUM_W-1:0] divisor,
  output scmn_pkg::unit_rsp_t        rsp,
  output logic [scmn_pkg::VAL_W-1:0] quot
);
  import scmn_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [SUM_W-1:0]  dv;
  logic [SUM_W:0]    rem;
  logic [STEP_W-1:0] steps;
  logic              running;
  logic [SUM_W:0]    rem_sh;

  assign rem_sh = {rem[SUM_W-1:0], 1'b0};

  // When the entry is at least the divisor the quotient is at least 1.0 and
  // saturates; otherwise 32 restoring steps give the fraction bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        dv <= divisor;
        rem <= {{(SUM_W + 1 - CNT_W){1'b0}}, entry};
        steps <= STEP_W'(CNT_W);
        if ({{(SUM_W - CNT_W){1'b0}}, entry} >= divisor) begin
          quot <= {1'b1, {CNT_W{1'b0}}};
          rsp.done <= 1'b1;
        end else begin
          quot <= '0;
          running <= 1'b1;
        end
      end else if (running) begin
        if (rem_sh >= {1'b0, dv}) begin
          rem <= rem_sh - {1'b0, dv};
          quot <= {quot[VAL_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quot <= {quot[VAL_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/sqrt_coverage_matrix_normalizer.sv @@
`timescale 1ns / 1ps
// Square-root coverage normalizer. Each word accepted on start (while busy is
// low) gives exactly one result word, shown for one cycle with done high; the
// receiver cannot stall it, so done must be sampled every cycle. Busy drops in
// the same cycle in which done is high, so the next word can be taken at the
// closing edge of that cycle. A load reads its entry and the row and column
// sums, then writes all three back, and does so a second time for its mirrored
// entry. A read fetches the entry and both sums from memory, forms and adds the
// four 20x20 partial products of the 80-bit sum product, runs the bit-serial
// square root (40 steps plus its start and hand-off) and then the restoring
// divider (32 steps plus its start and hand-off). When the entry is at least
// the root the quotient saturates at once and the divider skips its steps; a
// read whose row or column sum is zero answers straight after the memory read.
// Out-of-range items and mode 3 answer straight from the idle state. A clear
// sweeps all 65536 matrix entries, one per cycle, and the same sweep runs after
// reset with busy high, so the first item is taken only once it has ended.
// Configuration writes are always taken (cfg_ready is tied high) and must only
// be made while the block idles.
module sqrt_coverage_matrix_normalizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode,
  input  logic [7:0]                         row,
  input  logic [7:0]                         col,
  input  logic [scmn_pkg::CNT_W-1:0]         count,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [scmn_pkg::VAL_W-1:0]         value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scmn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scmn_pkg::SIZE_W-1:0]        cfg_data
);
  import scmn_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_USE, S_MUL, S_SQRT, S_DIV
  } state_t;

  localparam int HALF_W = SUM_W / 2;

  state_t              state;
  logic [SIZE_W-1:0]   row_count, col_count;
  logic                mirror_upper;
  logic [SIZE_W-1:0]   nr, nc;
  logic                is_read, mirror_pend, clr_report;
  logic [ROW_AW-1:0]   cur_r;
  logic [COL_AW-1:0]   cur_c;
  logic [CNT_W-1:0]    cnt_q, e_q;
  logic [MAT_AW-1:0]   clr_cnt;
  logic [SUM_W-1:0]    rs_q, cs_q;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0]   acc;
  logic [2:0]          mcnt;
  logic [HALF_W-1:0]   ma, mb;
  logic [PROD_W-1:0]   pp_sh;

  logic                mat_we, sum_we;
  logic [MAT_AW-1:0]   mat_addr;
  logic [CNT_W-1:0]    mat_wdata, mat_rdata;
  logic [ROW_AW-1:0]   rsum_addr;
  logic [COL_AW-1:0]   csum_addr;
  logic [SUM_W-1:0]    rsum_wdata, csum_wdata, rsum_rdata, csum_rdata;
  logic [SUM_W-1:0]    delta_new, delta_old;

  unit_req_t           sq_req, dv_req;
  unit_rsp_t           sq_rsp, dv_rsp;
  logic [SUM_W-1:0]    root;
  logic [VAL_W-1:0]    quot;

  // Sizes above the memory depth act as the depth.
  assign nr = (row_count > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : row_count;
  assign nc = (col_count > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : col_count;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Memory ports. The clear sweep owns all three memories; otherwise the
  // address is the current entry and the write happens in the cycle after
  // the read, when the old value is at hand.
  assign delta_new = {{(SUM_W - CNT_W){1'b0}}, cnt_q};
  assign delta_old = {{(SUM_W - CNT_W){1'b0}}, mat_rdata};
  assign mat_we    = (state == S_CLEAR) || (state == S_USE && !is_read);
  assign sum_we    = mat_we;
  assign mat_addr  = (state == S_CLEAR) ? clr_cnt : {cur_r, cur_c};
  assign mat_wdata = (state == S_CLEAR) ? '0 : cnt_q;
  assign rsum_addr = (state == S_CLEAR) ? clr_cnt[ROW_AW-1:0] : cur_r;
  assign csum_addr = (state == S_CLEAR) ? clr_cnt[COL_AW-1:0] : cur_c;
  assign rsum_wdata = (state == S_CLEAR) ? '0 : rsum_rdata + delta_new - delta_old;
  assign csum_wdata = (state == S_CLEAR) ? '0 : csum_rdata + delta_new - delta_old;

  scmn_ram #(.W(CNT_W), .DEPTH(MAT_DEPTH)) u_mat (
    .clk(clk), .we(mat_we), .addr(mat_addr), .wdata(mat_wdata), .rdata(mat_rdata)
  );
  scmn_ram #(.W(SUM_W), .DEPTH(MAX_ROWS)) u_rsum (
    .clk(clk), .we(sum_we), .addr(rsum_addr), .wdata(rsum_wdata), .rdata(rsum_rdata)
  );
  scmn_ram #(.W(SUM_W), .DEPTH(MAX_COLS)) u_csum (
    .clk(clk), .we(sum_we), .addr(csum_addr), .wdata(csum_wdata), .rdata(csum_rdata)
  );

  // Partial products of the sum product: low*low, low*high, high*low,
  // high*high, one per cycle, each registered before it is accumulated.
  always_comb begin
    case (mcnt[1:0])
      2'd0: begin ma = rs_q[HALF_W-1:0];     mb = cs_q[HALF_W-1:0];     end
      2'd1: begin ma = rs_q[HALF_W-1:0];     mb = cs_q[SUM_W-1:HALF_W]; end
      2'd2: begin ma = rs_q[SUM_W-1:HALF_W]; mb = cs_q[HALF_W-1:0];     end
      default: begin ma = rs_q[SUM_W-1:HALF_W]; mb = cs_q[SUM_W-1:HALF_W]; end
    endcase
    case (mcnt)
      3'd1: pp_sh = {{(PROD_W - 2*HALF_W){1'b0}}, pp};
      3'd2, 3'd3: pp_sh = {{(PROD_W - 3*HALF_W){1'b0}}, pp, {HALF_W{1'b0}}};
      default: pp_sh = {pp, {(2*HALF_W){1'b0}}};
    endcase
  end

  scmn_isqrt u_sqrt (
    .clk(clk), .rst(rst), .req(sq_req), .radicand(acc), .rsp(sq_rsp), .root(root)
  );
  scmn_div u_div (
    .clk(clk), .rst(rst), .req(dv_req), .entry(e_q), .divisor(root),
    .rsp(dv_rsp), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      clr_report <= 1'b0;
      row_count <= SIZE_W'(256);
      col_count <= SIZE_W'(256);
      mirror_upper <= 1'b0;
      done <= 1'b0;
      sq_req.start <= 1'b0;
      dv_req.start <= 1'b0;
    end else begin
      done <= 1'b0;
      sq_req.start <= 1'b0;
      dv_req.start <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count <= cfg_data;
          REG_COL_COUNT: col_count <= cfg_data;
          REG_MIRROR:    mirror_upper <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_IDLE;
            if (clr_report) begin
              done <= 1'b1;
              status <= ST_OK;
              value <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_r <= ROW_AW'(row);
            cur_c <= COL_AW'(col);
            cnt_q <= count;
            is_read <= (mode == MODE_READ);
            mirror_pend <= mirror_upper && (row != col) &&
                           ({1'b0, col} < nr) && ({1'b0, row} < nc);
            status <= ST_OK;
            value <= '0;
            case (mode)
              MODE_CLEAR: begin
                clr_report <= 1'b1;
                clr_cnt <= '0;
                state <= S_CLEAR;
              end
              MODE_LOAD, MODE_READ: begin
                if ({1'b0, row} >= nr) begin
                  status <= ST_ROW_ERR;
                  done <= 1'b1;
                end else if ({1'b0, col} >= nc) begin
                  status <= ST_COL_ERR;
                  done <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_READ: state <= S_USE;
        S_USE: begin
          if (is_read) begin
            rs_q <= rsum_rdata;
            cs_q <= csum_rdata;
            e_q <= mat_rdata;
            if (rsum_rdata == '0 || csum_rdata == '0) begin
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              mcnt <= '0;
              acc <= '0;
              state <= S_MUL;
            end
          end else if (mirror_pend) begin
            mirror_pend <= 1'b0;
            cur_r <= ROW_AW'(cur_c);
            cur_c <= COL_AW'(cur_r);
            state <= S_READ;
          end else begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          pp <= ma * mb;
          mcnt <= mcnt + 1'b1;
          if (mcnt != 3'd0) begin
            acc <= acc + pp_sh;
          end
          if (mcnt == 3'd4) begin
            sq_req.start <= 1'b1;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_rsp.done) begin
            dv_req.start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_rsp.done) begin
            value <= quot;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
